@@ hw/rtl/s5hs_pkg.sv @@
`default_nettype none
package s5hs_pkg;

    localparam int MAX_HOST = 56;
    localparam int HOST_AW  = (MAX_HOST > 1) ? $clog2(MAX_HOST) : 1;
    localparam int IDX_W    = 7;

    // input commands
    localparam logic [2:0] CMD_CLIENT  = 3'd0;
    localparam logic [2:0] CMD_TARGET  = 3'd1;
    localparam logic [2:0] CMD_VERDICT = 3'd2;
    localparam logic [2:0] CMD_OUTCOME = 3'd3;
    localparam logic [2:0] CMD_CLOSED  = 3'd4;

    // result destinations
    localparam logic [2:0] DEST_CLIENT = 3'd0;
    localparam logic [2:0] DEST_TARGET = 3'd1;
    localparam logic [2:0] DEST_CRED   = 3'd2;
    localparam logic [2:0] DEST_CONN   = 3'd3;
    localparam logic [2:0] DEST_CLOSE  = 3'd4;

    // close reasons
    localparam logic [1:0] RSN_VERSION = 2'd0;
    localparam logic [1:0] RSN_REFUSED = 2'd1;
    localparam logic [1:0] RSN_PEER    = 2'd2;
    localparam logic [1:0] RSN_ORDER   = 2'd3;

    // protocol bytes
    localparam logic [7:0] SOCKS_VER      = 8'h05;
    localparam logic [7:0] AUTH_VER       = 8'h01;
    localparam logic [7:0] METH_NONE      = 8'h00;
    localparam logic [7:0] METH_USERPASS  = 8'h02;
    localparam logic [7:0] NO_METHOD      = 8'hFF;
    localparam logic [7:0] REQ_CONNECT    = 8'h01;
    localparam logic [7:0] ATYP_IPV4      = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
    localparam logic [7:0] REP_OK         = 8'h00;
    localparam logic [7:0] REP_FAIL       = 8'h05;
    localparam logic [7:0] REP_CMD_UNSUP  = 8'h07;
    localparam logic [7:0] REP_ATYP_UNSUP = 8'h08;
    localparam logic [7:0] RSV_BYTE       = 8'h00;
    localparam logic [7:0] AUTH_OK        = 8'h00;
    localparam logic [7:0] AUTH_FAIL      = 8'hFF;
    localparam logic [7:0] IPV4_TGT_LEN   = 8'd6;

    typedef enum logic [2:0] {
        JOB_ONE   = 3'd0,
        JOB_CLOSE = 3'd1,
        JOB_R2    = 3'd2,
        JOB_R4    = 3'd3,
        JOB_CONN  = 3'd4
    } job_kind_t;

    typedef enum logic [1:0] {
        BL_BYTE = 2'd0,
        BL_SIX  = 2'd1,
        BL_DLEN = 2'd2
    } bl_sel_t;

    typedef struct packed {
        logic       start;
        job_kind_t  kind;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       close_after;
        logic [1:0] reason;
        logic [2:0] dest;
        logic       part;
        logic       no_data;
        logic       last;
        logic       bc_clr;
        logic       bc_inc;
        logic       bl_we;
        bl_sel_t    bl_sel;
        logic       bl_dec;
        logic       ms_clr;
        logic       ms_set;
        logic       pb_load;
        logic       pb_shift;
        logic       pb_clr;
        logic       ip_clr;
        logic       ip_shift;
        logic       dt_we;
        logic       dt_val;
        logic       hl_we;
        logic       host_we;
    } dp_cmd_t;

    typedef struct packed {
        logic        busy;
        logic [7:0]  bc;
        logic [7:0]  bl;
        logic [7:0]  hl;
        logic        ms;
        logic [15:0] pb;
    } dp_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/socks5_server_handshake.sv @@
`default_nettype none
// SOCKS5 server handshake (CONNECT, IPv4 or domain target). Input beats are taken one
// at a time: a beat that yields result beats keeps s_ready low until the last of them
// has entered the output register, since the reply sequencer feeds that register one
// beat per cycle unless a low m_ready holds it off (longest case: the refused connect
// reply for a 56-byte domain, 64 beats with its close). A beat with no result leaves
// s_ready high. Host name bytes sit in a small RAM that the
// connect reply reads back in order. auth_required is written through the APB port at
// byte address 0 and should only change while the block is idle.
module socks5_server_handshake (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_cmd,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_ok,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_dest,
    output logic [7:0]      m_out_byte,
    output logic            m_part,
    output logic            m_no_data,
    output logic            m_last,
    output logic [1:0]      m_close_reason
);
    import s5hs_pkg::*;

    logic    auth_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, auth_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auth_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            auth_reg <= pwdata[0];
        end
    end

    s5hs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_data_byte   (s_data_byte),
        .s_ok          (s_ok),
        .auth_required (auth_reg),
        .sts           (sts),
        .cmd           (cmd)
    );

    s5hs_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_data_byte    (s_data_byte),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dest         (m_dest),
        .m_out_byte     (m_out_byte),
        .m_part         (m_part),
        .m_no_data      (m_no_data),
        .m_last         (m_last),
        .m_close_reason (m_close_reason)
    );

    // a close is always the final beat of its reply
    a_close_ends_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_dest == DEST_CLOSE) |=> !sts.busy)
        else $error("close beat not final");

    a_nodata_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_data) |-> (m_dest == DEST_CRED && m_part && m_last))
        else $error("empty-password beat malformed");

    a_reason_only_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_close_reason != RSN_VERSION) |-> m_dest == DEST_CLOSE)
        else $error("close reason on non-close beat");

    a_no_start_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.busy |-> !cmd.start)
        else $error("job started while sequencer busy");
endmodule
`default_nettype wire

@@ hw/rtl/s5hs_ram.sv @@
`default_nettype none
module s5hs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 56
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/s5hs_ctrl.sv @@
`default_nettype none
module s5hs_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_cmd,
    input  wire logic [7:0]         s_data_byte,
    input  wire logic               s_ok,
    input  wire logic               auth_required,
    input  wire s5hs_pkg::dp_sts_t  sts,
    output s5hs_pkg::dp_cmd_t       cmd
);
    import s5hs_pkg::*;

    typedef enum logic [13:0] {
        PH_HDR       = 14'b00000000000001,
        PH_METHODS   = 14'b00000000000010,
        PH_AUTH_HDR  = 14'b00000000000100,
        PH_USER      = 14'b00000000001000,
        PH_PLEN      = 14'b00000000010000,
        PH_PASS      = 14'b00000000100000,
        PH_AUTH_WAIT = 14'b00000001000000,
        PH_REQ_HDR   = 14'b00000010000000,
        PH_IPV4      = 14'b00000100000000,
        PH_DLEN      = 14'b00001000000000,
        PH_DOMAIN    = 14'b00010000000000,
        PH_CONN_WAIT = 14'b00100000000000,
        PH_RELAY     = 14'b01000000000000,
        PH_CLOSED    = 14'b10000000000000
    } phase_t;

    phase_t phase_reg, phase_next;

    function automatic dp_cmd_t j_close(dp_cmd_t c, logic [1:0] r);
        dp_cmd_t o;
        o             = c;
        o.start       = 1'b1;
        o.kind        = JOB_CLOSE;
        o.close_after = 1'b1;
        o.reason      = r;
        return o;
    endfunction

    function automatic dp_cmd_t j_one(dp_cmd_t c, logic [2:0] d, logic [7:0] b,
                                      logic p, logic nd, logic l);
        dp_cmd_t o;
        o         = c;
        o.start   = 1'b1;
        o.kind    = JOB_ONE;
        o.dest    = d;
        o.byte0   = b;
        o.part    = p;
        o.no_data = nd;
        o.last    = l;
        return o;
    endfunction

    function automatic dp_cmd_t j_r2(dp_cmd_t c, logic [7:0] a, logic [7:0] b,
                                     logic cl);
        dp_cmd_t o;
        o             = c;
        o.start       = 1'b1;
        o.kind        = JOB_R2;
        o.byte0       = a;
        o.byte1       = b;
        o.close_after = cl;
        o.reason      = RSN_REFUSED;
        return o;
    endfunction

    function automatic dp_cmd_t j_r4(dp_cmd_t c, logic [7:0] code);
        dp_cmd_t o;
        o             = c;
        o.start       = 1'b1;
        o.kind        = JOB_R4;
        o.byte1       = code;
        o.close_after = 1'b1;
        o.reason      = RSN_REFUSED;
        return o;
    endfunction

    logic       acc;
    logic [7:0] want;
    logic [7:0] ver;
    logic       bl_one;

    assign s_ready = !sts.busy;
    assign acc     = s_valid && s_ready;
    assign want    = auth_required ? METH_USERPASS : METH_NONE;
    assign ver     = (phase_reg == PH_HDR) ? SOCKS_VER : AUTH_VER;
    assign bl_one  = (sts.bl == 8'd1);

    always_comb begin
        cmd        = '0;
        phase_next = phase_reg;
        if (acc && phase_reg != PH_CLOSED && s_cmd <= CMD_CLOSED) begin
            if (s_cmd == CMD_CLOSED) begin
                cmd        = j_close(cmd, RSN_PEER);
                phase_next = PH_CLOSED;
            end else if (phase_reg == PH_RELAY) begin
                if (s_cmd == CMD_CLIENT) begin
                    cmd = j_one(cmd, DEST_TARGET, s_data_byte, 1'b0, 1'b0, 1'b0);
                end else if (s_cmd == CMD_TARGET) begin
                    cmd = j_one(cmd, DEST_CLIENT, s_data_byte, 1'b0, 1'b0, 1'b0);
                end else begin
                    cmd        = j_close(cmd, RSN_ORDER);
                    phase_next = PH_CLOSED;
                end
            end else if (s_cmd == CMD_VERDICT) begin
                if (phase_reg != PH_AUTH_WAIT) begin
                    cmd        = j_close(cmd, RSN_ORDER);
                    phase_next = PH_CLOSED;
                end else if (s_ok) begin
                    cmd        = j_r2(cmd, AUTH_VER, AUTH_OK, 1'b0);
                    cmd.bc_clr = 1'b1;
                    phase_next = PH_REQ_HDR;
                end else begin
                    cmd        = j_r2(cmd, AUTH_VER, AUTH_FAIL, 1'b1);
                    phase_next = PH_CLOSED;
                end
            end else if (s_cmd == CMD_OUTCOME) begin
                if (phase_reg != PH_CONN_WAIT) begin
                    cmd        = j_close(cmd, RSN_ORDER);
                    phase_next = PH_CLOSED;
                end else begin
                    cmd.start       = 1'b1;
                    cmd.kind        = JOB_CONN;
                    cmd.byte1       = s_ok ? REP_OK : REP_FAIL;
                    cmd.close_after = !s_ok;
                    cmd.reason      = RSN_REFUSED;
                    phase_next      = s_ok ? PH_RELAY : PH_CLOSED;
                end
            end else if (s_cmd == CMD_TARGET) begin
                cmd        = j_close(cmd, RSN_ORDER);
                phase_next = PH_CLOSED;
            end else begin
                case (phase_reg)
                    PH_HDR, PH_AUTH_HDR: begin
                        if (sts.bc == 8'd0) begin
                            cmd.pb_load = 1'b1;
                            cmd.bc_inc  = 1'b1;
                        end else begin
                            cmd.bc_clr = 1'b1;
                            if (sts.pb != {8'd0, ver}) begin
                                cmd        = j_close(cmd, RSN_VERSION);
                                phase_next = PH_CLOSED;
                            end else if (s_data_byte == 8'd0) begin
                                cmd        = j_r2(cmd, ver, NO_METHOD, 1'b1);
                                phase_next = PH_CLOSED;
                            end else begin
                                cmd.bl_we  = 1'b1;
                                cmd.bl_sel = BL_BYTE;
                                cmd.ms_clr = 1'b1;
                                phase_next = (phase_reg == PH_HDR) ? PH_METHODS : PH_USER;
                            end
                        end
                    end
                    PH_METHODS: begin
                        cmd.ms_set = (s_data_byte == want);
                        cmd.bl_dec = 1'b1;
                        if (bl_one) begin
                            if (sts.ms || s_data_byte == want) begin
                                cmd        = j_r2(cmd, SOCKS_VER, want, 1'b0);
                                phase_next = auth_required ? PH_AUTH_HDR : PH_REQ_HDR;
                            end else begin
                                cmd        = j_r2(cmd, SOCKS_VER, NO_METHOD, 1'b1);
                                phase_next = PH_CLOSED;
                            end
                        end
                    end
                    PH_USER: begin
                        cmd        = j_one(cmd, DEST_CRED, s_data_byte, 1'b0, 1'b0, bl_one);
                        cmd.bl_dec = 1'b1;
                        if (bl_one) begin
                            phase_next = PH_PLEN;
                        end
                    end
                    PH_PLEN: begin
                        if (s_data_byte == 8'd0) begin
                            cmd        = j_one(cmd, DEST_CRED, 8'd0, 1'b1, 1'b1, 1'b1);
                            phase_next = PH_AUTH_WAIT;
                        end else begin
                            cmd.bl_we  = 1'b1;
                            cmd.bl_sel = BL_BYTE;
                            phase_next = PH_PASS;
                        end
                    end
                    PH_PASS: begin
                        cmd        = j_one(cmd, DEST_CRED, s_data_byte, 1'b1, 1'b0, bl_one);
                        cmd.bl_dec = 1'b1;
                        if (bl_one) begin
                            phase_next = PH_AUTH_WAIT;
                        end
                    end
                    PH_REQ_HDR: begin
                        if (sts.bc < 8'd2) begin
                            cmd.pb_shift = 1'b1;
                            cmd.bc_inc   = 1'b1;
                        end else if (sts.bc == 8'd2) begin
                            cmd.bc_inc = 1'b1;
                        end else begin
                            cmd.bc_clr = 1'b1;
                            if (sts.pb[15:8] != SOCKS_VER) begin
                                cmd        = j_close(cmd, RSN_VERSION);
                                phase_next = PH_CLOSED;
                            end else if (sts.pb[7:0] != REQ_CONNECT) begin
                                cmd        = j_r4(cmd, REP_CMD_UNSUP);
                                phase_next = PH_CLOSED;
                            end else if (s_data_byte == ATYP_IPV4) begin
                                cmd.dt_we  = 1'b1;
                                cmd.dt_val = 1'b0;
                                cmd.ip_clr = 1'b1;
                                cmd.bl_we  = 1'b1;
                                cmd.bl_sel = BL_SIX;
                                phase_next = PH_IPV4;
                            end else if (s_data_byte == ATYP_DOMAIN) begin
                                cmd.dt_we  = 1'b1;
                                cmd.dt_val = 1'b1;
                                phase_next = PH_DLEN;
                            end else begin
                                cmd        = j_r4(cmd, REP_ATYP_UNSUP);
                                phase_next = PH_CLOSED;
                            end
                        end
                    end
                    PH_IPV4: begin
                        cmd          = j_one(cmd, DEST_CONN, s_data_byte, 1'b0, 1'b0, bl_one);
                        cmd.ip_shift = 1'b1;
                        cmd.bl_dec   = 1'b1;
                        if (bl_one) begin
                            phase_next = PH_CONN_WAIT;
                        end
                    end
                    PH_DLEN: begin
                        if (s_data_byte > 8'(MAX_HOST)) begin
                            cmd        = j_r4(cmd, REP_ATYP_UNSUP);
                            phase_next = PH_CLOSED;
                        end else begin
                            cmd        = j_one(cmd, DEST_CONN, s_data_byte, 1'b1, 1'b0, 1'b0);
                            cmd.hl_we  = 1'b1;
                            cmd.bc_clr = 1'b1;
                            cmd.bl_we  = 1'b1;
                            cmd.bl_sel = BL_DLEN;
                            cmd.pb_clr = 1'b1;
                            phase_next = PH_DOMAIN;
                        end
                    end
                    PH_DOMAIN: begin
                        cmd = j_one(cmd, DEST_CONN, s_data_byte, 1'b1, 1'b0, bl_one);
                        if (sts.bc < sts.hl) begin
                            cmd.host_we = 1'b1;
                        end else begin
                            cmd.pb_shift = 1'b1;
                        end
                        cmd.bc_inc = 1'b1;
                        cmd.bl_dec = 1'b1;
                        if (bl_one) begin
                            phase_next = PH_CONN_WAIT;
                        end
                    end
                    default: begin
                        cmd        = j_close(cmd, RSN_ORDER);
                        phase_next = PH_CLOSED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR;
        end else begin
            phase_reg <= phase_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/s5hs_dp.sv @@
`default_nettype none
module s5hs_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        s_data_byte,
    input  wire s5hs_pkg::dp_cmd_t cmd,
    output s5hs_pkg::dp_sts_t      sts,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_dest,
    output logic [7:0]             m_out_byte,
    output logic                   m_part,
    output logic                   m_no_data,
    output logic                   m_last,
    output logic [1:0]             m_close_reason
);
    import s5hs_pkg::*;

    logic [7:0]  bc_reg, bl_reg, hl_reg;
    logic        ms_reg, dt_reg;
    logic [15:0] pb_reg;
    logic [47:0] ip_reg;

    // job captured at accept, replayed one beat per cycle while m_ready does not stall the output
    job_kind_t  kind_reg;
    logic [7:0] byte0_reg, byte1_reg;
    logic       close_after_reg;
    logic [1:0] reason_reg;
    logic [2:0] dest_reg;
    logic       part_reg, nd_reg, last_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic       busy_reg;

    logic       ovalid_reg;
    logic [2:0] odest_reg;
    logic [7:0] obyte_reg;
    logic       opart_reg, ond_reg, olast_reg;
    logic [1:0] oreason_reg;

    logic [7:0] host_rd;
    logic [7:0] raddr_wide;
    logic       adv;
    logic [7:0] i;
    logic [7:0] n_body;
    logic [7:0] ip_sel;
    logic       item_final;
    logic [2:0] it_dest;
    logic [7:0] it_byte;
    logic       it_part, it_nd, it_last;
    logic [1:0] it_reason;

    assign adv        = busy_reg && (!ovalid_reg || m_ready);
    assign idx_next   = cmd.start ? '0 : (adv ? idx_reg + 1'b1 : idx_reg);
    assign raddr_wide = 8'(idx_next) - 8'd5;
    assign i          = 8'(idx_reg);
    assign ip_sel     = i - 8'd4;

    s5hs_ram #(.WIDTH(8), .DEPTH(MAX_HOST)) u_host (
        .clk   (aclk),
        .we    (cmd.host_we),
        .waddr (bc_reg[HOST_AW-1:0]),
        .wdata (s_data_byte),
        .raddr (raddr_wide[HOST_AW-1:0]),
        .rdata (host_rd)
    );

    always_comb begin
        case (kind_reg)
            JOB_ONE:   n_body = 8'd1;
            JOB_CLOSE: n_body = 8'd0;
            JOB_R2:    n_body = 8'd2;
            JOB_R4:    n_body = 8'd4;
            JOB_CONN:  n_body = dt_reg ? hl_reg + 8'd7 : 8'd10;
            default:   n_body = 8'd0;
        endcase
    end

    assign item_final = close_after_reg ? (i == n_body) : (i == n_body - 8'd1);

    always_comb begin
        it_dest   = DEST_CLIENT;
        it_byte   = 8'd0;
        it_part   = 1'b0;
        it_nd     = 1'b0;
        it_last   = 1'b0;
        it_reason = 2'd0;
        if (close_after_reg && i == n_body) begin
            it_dest   = DEST_CLOSE;
            it_reason = reason_reg;
        end else begin
            case (kind_reg)
                JOB_ONE: begin
                    it_dest = dest_reg;
                    it_byte = byte0_reg;
                    it_part = part_reg;
                    it_nd   = nd_reg;
                    it_last = last_reg;
                end
                JOB_R2: begin
                    it_byte = (i == 8'd0) ? byte0_reg : byte1_reg;
                    it_last = (i == 8'd1);
                end
                JOB_R4, JOB_CONN: begin
                    if (i < 8'd4) begin
                        case (i[1:0])
                            2'd0:    it_byte = SOCKS_VER;
                            2'd1:    it_byte = byte1_reg;
                            2'd2:    it_byte = RSV_BYTE;
                            default: begin
                                it_byte = (kind_reg == JOB_CONN && dt_reg) ?
                                          ATYP_DOMAIN : ATYP_IPV4;
                                it_last = (kind_reg == JOB_R4);
                            end
                        endcase
                    end else if (!dt_reg) begin
                        case (ip_sel[2:0])
                            3'd0:    it_byte = ip_reg[47:40];
                            3'd1:    it_byte = ip_reg[39:32];
                            3'd2:    it_byte = ip_reg[31:24];
                            3'd3:    it_byte = ip_reg[23:16];
                            3'd4:    it_byte = ip_reg[15:8];
                            default: it_byte = ip_reg[7:0];
                        endcase
                        it_last = (ip_sel == 8'd5);
                    end else if (i == 8'd4) begin
                        it_byte = hl_reg;
                    end else if (i < hl_reg + 8'd5) begin
                        it_byte = host_rd;
                    end else if (i == hl_reg + 8'd5) begin
                        it_byte = pb_reg[15:8];
                    end else begin
                        it_byte = pb_reg[7:0];
                        it_last = 1'b1;
                    end
                end
                default: begin
                    it_byte = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg     <= '0;
            bl_reg     <= '0;
            hl_reg     <= '0;
            ms_reg     <= 1'b0;
            dt_reg     <= 1'b0;
            pb_reg     <= '0;
            ip_reg     <= '0;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            if (cmd.bc_clr) begin
                bc_reg <= '0;
            end else if (cmd.bc_inc) begin
                bc_reg <= bc_reg + 8'd1;
            end
            if (cmd.bl_we) begin
                case (cmd.bl_sel)
                    BL_BYTE: bl_reg <= s_data_byte;
                    BL_SIX:  bl_reg <= IPV4_TGT_LEN;
                    BL_DLEN: bl_reg <= s_data_byte + 8'd2;
                    default: bl_reg <= s_data_byte;
                endcase
            end else if (cmd.bl_dec) begin
                bl_reg <= bl_reg - 8'd1;
            end
            if (cmd.ms_clr) begin
                ms_reg <= 1'b0;
            end else if (cmd.ms_set) begin
                ms_reg <= 1'b1;
            end
            if (cmd.pb_clr) begin
                pb_reg <= '0;
            end else if (cmd.pb_load) begin
                pb_reg <= {8'd0, s_data_byte};
            end else if (cmd.pb_shift) begin
                pb_reg <= {pb_reg[7:0], s_data_byte};
            end
            if (cmd.ip_clr) begin
                ip_reg <= '0;
            end else if (cmd.ip_shift) begin
                ip_reg <= {ip_reg[39:0], s_data_byte};
            end
            if (cmd.dt_we) begin
                dt_reg <= cmd.dt_val;
            end
            if (cmd.hl_we) begin
                hl_reg <= s_data_byte;
            end
            idx_reg <= idx_next;
            if (cmd.start) begin
                busy_reg <= 1'b1;
            end else if (adv && item_final) begin
                busy_reg <= 1'b0;
            end
            if (adv) begin
                ovalid_reg <= 1'b1;
            end else if (m_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            kind_reg        <= cmd.kind;
            byte0_reg       <= cmd.byte0;
            byte1_reg       <= cmd.byte1;
            close_after_reg <= cmd.close_after;
            reason_reg      <= cmd.reason;
            dest_reg        <= cmd.dest;
            part_reg        <= cmd.part;
            nd_reg          <= cmd.no_data;
            last_reg        <= cmd.last;
        end
        if (adv) begin
            odest_reg   <= it_dest;
            obyte_reg   <= it_byte;
            opart_reg   <= it_part;
            ond_reg     <= it_nd;
            olast_reg   <= it_last;
            oreason_reg <= it_reason;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.bc   = bc_reg;
    assign sts.bl   = bl_reg;
    assign sts.hl   = hl_reg;
    assign sts.ms   = ms_reg;
    assign sts.pb   = pb_reg;

    assign m_valid        = ovalid_reg;
    assign m_dest         = odest_reg;
    assign m_out_byte     = obyte_reg;
    assign m_part         = opart_reg;
    assign m_no_data      = ond_reg;
    assign m_last         = olast_reg;
    assign m_close_reason = oreason_reg;
endmodule
`default_nettype wire
